@@ sv/sgi_pkg.sv @@
// ----------------------------------------------------------------------------
// sgi_pkg: shared types for the stereo gap interpolator
// Sequencer states and the lane control group.
// ----------------------------------------------------------------------------
package sgi_pkg;

	// Work state of the item held in the first stage.
	typedef enum logic [1:0] {
		SGI_EMPTY,
		SGI_DIV,
		SGI_FILL,
		SGI_FINAL
	} sgi_state_t;

	// Commands from the sequencer to each channel lane.
	typedef struct packed {
		logic load;
		logic div_step;
		logic fill_step;
	} lane_ctrl_t;

endpackage

@@ sv/sgi_lane.sv @@
// ----------------------------------------------------------------------------
// sgi_lane: one channel of the fill generator
// Splits |good - prev| into quotient and remainder by the fill divisor with
// one reciprocal multiply, then walks the fill steps with one add and compare
// each.
// ----------------------------------------------------------------------------
module sgi_lane import sgi_pkg::*; #(
	parameter int GAP_FILL_LENGTH = 5,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  lane_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] cur,
	input  logic signed [SAMPLE_BITS-1:0] prev,
	output logic signed [SAMPLE_BITS-1:0] fill_val
);

	localparam int SB = SAMPLE_BITS;
	localparam int DIVISOR = GAP_FILL_LENGTH + 1;
	localparam int RW = $clog2(DIVISOR);
	localparam int SHIFT = SB + RW;
	localparam logic [RW:0] DIV_C = (RW + 1)'(DIVISOR);
	// Scaled reciprocal of the divisor, rounded up, so that the upper product
	// bits give the exact quotient of any magnitude of SB bits.
	localparam logic [SB:0] RECIP =
		(SB + 1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic [SB-1:0]             prev_q;
	logic                      neg_q;
	logic [SB-1:0]             mag_q;
	logic [SB-1:0]             quo_q;
	logic [RW-1:0]             rem_q;
	logic [SB-1:0]             q_q;
	logic [RW-1:0]             r_q;

	logic [SB:0]               diff;
	logic [SB:0]               mag_w;
	logic [2*SB:0]             prod;
	logic [SB-1:0]             quo_w;
	logic [RW-1:0]             rem_w;
	logic [RW:0]               sum_r;
	logic                      carry;
	logic [RW-1:0]             r_next;
	logic [SB-1:0]             q_next;
	logic [SB:0]               q_signed;
	logic [SB:0]               fill_sum;

	// Difference to the new good frame, kept as sign and magnitude.
	assign diff = {cur[SB-1], cur} - {prev[SB-1], prev};
	assign mag_w = diff[SB] ? (~diff + 1'b1) : diff;

	// Quotient by reciprocal multiply; the remainder needs only its low bits.
	assign prod = mag_q * RECIP;
	assign quo_w = SB'(prod >> SHIFT);
	assign rem_w = mag_q[RW-1:0] - quo_w[RW-1:0] * DIV_C[RW-1:0];

	// Next fill step: add the quotient and carry the remainder.
	always_comb begin
		sum_r = {1'b0, r_q} + {1'b0, rem_q};
		carry = (sum_r >= DIV_C);
		r_next = carry ? RW'(sum_r - DIV_C) : sum_r[RW-1:0];
		q_next = q_q + quo_q + SB'(carry);
	end

	// Fill sample is the previous value moved toward the good one.
	assign q_signed = neg_q ? (~{1'b0, q_q} + 1'b1) : {1'b0, q_q};
	assign fill_sum = {prev_q[SB-1], prev_q} + q_signed;
	assign fill_val = fill_sum[SB-1:0];

	// Working registers of the lane.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prev_q <= prev;
			neg_q <= diff[SB];
			mag_q <= mag_w[SB-1:0];
		end else if (ctrl.div_step) begin
			quo_q <= quo_w;
			rem_q <= rem_w;
			q_q <= quo_w;
			r_q <= rem_w;
		end else if (ctrl.fill_step) begin
			q_q <= q_next;
			r_q <= r_next;
		end
	end

endmodule

@@ sv/stereo_gap_interpolator.sv @@
// ----------------------------------------------------------------------------
// stereo_gap_interpolator: dropout repair for a stereo sample stream
// Good frames pass through; a run of gap frames becomes a fixed number of
// interpolated fill frames emitted ahead of the next good frame.
// ----------------------------------------------------------------------------
// Usage: frames enter on the in channel (in_valid/in_ready) and results
// leave on the out channel (out_valid/out_ready). A frame with either
// channel zero is a gap frame and gives no result unless it ends the stream,
// in which case GAP_FILL_LENGTH zero fill frames come out.
// A good frame is held in the first stage and then written to the result
// buffer. A good frame that closes a gap first passes the lane divider,
// then emits GAP_FILL_LENGTH fill frames and itself through the single
// result port, one per cycle while the buffer has space. Throughput: one
// item per cycle for dropped gap frames, and for good frames while the
// buffer has space; a gap-closing item holds the input until its last result.
// The result side is a two-entry buffer, so in_ready never depends on
// out_ready in the same cycle. When the receiver stalls, the buffer fills
// and the input stops one item later. Reset clears the last good frame to
// zero, closes any open gap and empties the pipeline.
// ----------------------------------------------------------------------------
module stereo_gap_interpolator import sgi_pkg::*; #(
	parameter int GAP_FILL_LENGTH = 5,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          filled,
	output logic                          last_of_burst
);

	localparam int SB = SAMPLE_BITS;
	localparam int KW = $clog2(GAP_FILL_LENGTH + 1);
	localparam logic [KW-1:0] K_LAST = KW'(GAP_FILL_LENGTH);

	// Stream state.
	logic signed [SB-1:0] prev_left_q;
	logic signed [SB-1:0] prev_right_q;
	logic                 gap_pending_q;

	// First stage: the item being worked on.
	logic signed [SB-1:0] left_s1;
	logic signed [SB-1:0] right_s1;
	logic                 zero_s1;
	sgi_state_t           state_q;
	sgi_state_t           state_d;
	logic [KW-1:0]        k_q;
	logic [KW-1:0]        k_d;

	// Result buffer.
	logic signed [SB-1:0] out_left_q [2];
	logic signed [SB-1:0] out_right_q [2];
	logic                 out_filled_q [2];
	logic                 out_last_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	logic                 space;
	logic                 pop;
	logic                 accept;
	logic                 gap_in;
	logic                 load;
	logic                 done;
	logic                 push;
	logic signed [SB-1:0] push_left;
	logic signed [SB-1:0] push_right;
	logic                 push_filled;
	logic                 push_last;
	lane_ctrl_t           ctrl;
	logic signed [SB-1:0] fill_left;
	logic signed [SB-1:0] fill_right;

	assign space = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop = out_valid && out_ready;
	assign gap_in = (left_in == '0) || (right_in == '0);

	// Sequencer: next state, result selection and lane commands.
	always_comb begin
		state_d = state_q;
		k_d = k_q;
		done = 1'b0;
		push = 1'b0;
		push_left = '0;
		push_right = '0;
		push_filled = 1'b0;
		push_last = 1'b0;
		ctrl = '0;
		case (state_q)
			SGI_EMPTY: begin
				state_d = SGI_EMPTY;
			end
			SGI_DIV: begin
				ctrl.div_step = 1'b1;
				state_d = SGI_FILL;
				k_d = KW'(1);
			end
			SGI_FILL: begin
				if (space) begin
					push = 1'b1;
					push_filled = 1'b1;
					if (!zero_s1) begin
						push_left = fill_left;
						push_right = fill_right;
					end
					if (k_q == K_LAST) begin
						if (zero_s1) begin
							push_last = 1'b1;
							done = 1'b1;
							state_d = SGI_EMPTY;
						end else begin
							state_d = SGI_FINAL;
						end
					end else begin
						k_d = k_q + 1'b1;
						ctrl.fill_step = !zero_s1;
					end
				end
			end
			SGI_FINAL: begin
				if (space) begin
					push = 1'b1;
					push_left = left_s1;
					push_right = right_s1;
					push_last = 1'b1;
					done = 1'b1;
					state_d = SGI_EMPTY;
				end
			end
			default: begin
				state_d = SGI_EMPTY;
			end
		endcase

		in_ready = (state_q == SGI_EMPTY) || done;
		accept = in_valid && in_ready;
		load = accept && !(gap_in && !end_of_stream);

		// A new item takes the first stage as the old one leaves.
		if (load) begin
			ctrl.load = 1'b1;
			k_d = KW'(1);
			if (gap_in) begin
				state_d = SGI_FILL;
			end else if (gap_pending_q) begin
				state_d = SGI_DIV;
			end else begin
				state_d = SGI_FINAL;
			end
		end
	end

	// Sequencer and stream state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SGI_EMPTY;
			k_q <= KW'(1);
			prev_left_q <= '0;
			prev_right_q <= '0;
			gap_pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			if (accept) begin
				if (end_of_stream) begin
					prev_left_q <= '0;
					prev_right_q <= '0;
					gap_pending_q <= 1'b0;
				end else if (gap_in) begin
					gap_pending_q <= 1'b1;
				end else begin
					prev_left_q <= left_in;
					prev_right_q <= right_in;
					gap_pending_q <= 1'b0;
				end
			end
		end
	end

	// First stage payload.
	always_ff @(posedge clk) begin
		if (load) begin
			left_s1 <= left_in;
			right_s1 <= right_in;
			zero_s1 <= gap_in;
		end
	end

	// Channel lanes produce the interpolated samples.
	sgi_lane #(
		.GAP_FILL_LENGTH(GAP_FILL_LENGTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_left (
		.clk(clk),
		.ctrl(ctrl),
		.cur(left_in),
		.prev(prev_left_q),
		.fill_val(fill_left)
	);

	sgi_lane #(
		.GAP_FILL_LENGTH(GAP_FILL_LENGTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_right (
		.clk(clk),
		.ctrl(ctrl),
		.cur(right_in),
		.prev(prev_right_q),
		.fill_val(fill_right)
	);

	// Result buffer pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Result buffer entries.
	always_ff @(posedge clk) begin
		if (push) begin
			out_left_q[wr_ptr_q] <= push_left;
			out_right_q[wr_ptr_q] <= push_right;
			out_filled_q[wr_ptr_q] <= push_filled;
			out_last_q[wr_ptr_q] <= push_last;
		end
	end

	assign left_out = out_left_q[rd_ptr_q];
	assign right_out = out_right_q[rd_ptr_q];
	assign filled = out_filled_q[rd_ptr_q];
	assign last_of_burst = out_last_q[rd_ptr_q];

	// The buffer never holds more than two results.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer overfilled");

	// Nothing is emitted while the stage is empty or dividing.
	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SGI_EMPTY || state_q == SGI_DIV) |-> !push)
		else $error("result emitted without work");

	// The last result of an item is exactly the one that frees the stage.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_last == done))
		else $error("burst end and stage release disagree");

	// Fill step counter stays within the burst.
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SGI_FILL |-> (k_q != '0 && k_q <= K_LAST))
		else $error("fill step out of range");

	// The division state always leads into the fill burst.
	a_div_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SGI_DIV |=> state_q == SGI_FILL)
		else $error("division did not hand over to fill");

endmodule
